/* design/cau_pkg.sv */
package cau_pkg;

    // Fixed-point format of all operand and result parts.
    localparam int FRAC_BITS = 16;

    // Quotient bits developed by the divide pipeline, one per stage.
    localparam int DIV_STEPS = 32;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_CMP = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] x_real;
        logic signed [31:0] x_imag;
        logic signed [31:0] y_real;
        logic signed [31:0] y_imag;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic               is_equal;
        logic               div_zero;
        logic               saturated;
    } rsp_t;

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } sat_t;

    localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
    localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

    // Clip a wide signed value to the 32-bit two's complement range.
    function automatic sat_t sat32(input logic signed [64:0] v);
        sat_t r;
        if (v > SAT_MAX)
        begin
            r.val  = 32'h7FFF_FFFF;
            r.clip = 1'b1;
        end
        else if (v < SAT_MIN)
        begin
            r.val  = 32'h8000_0000;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Apply the sign to an unsigned quotient and clip it; ovf means quotient >= 2^32.
    function automatic sat_t quo_sat(input logic neg, input logic ovf, input logic [31:0] q);
        sat_t r;
        if (!neg)
        begin
            if (ovf || q[31])
            begin
                r.val  = 32'h7FFF_FFFF;
                r.clip = 1'b1;
            end
            else
            begin
                r.val  = q;
                r.clip = 1'b0;
            end
        end
        else
        begin
            if (ovf || q > 32'h8000_0000)
            begin
                r.val  = 32'h8000_0000;
                r.clip = 1'b1;
            end
            else
            begin
                r.val  = 32'd0 - q;
                r.clip = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

/* design/complex_arith_unit_top.sv */
// Channel | Signals                   | Transaction
// req     | req_valid, req_ready, req | one operand pair and an action
// rsp     | rsp_valid, rsp_ready, rsp | one result
//
// Every action runs through the same pipeline of DIV_STEPS + 5 register stages:
// products, sums, magnitudes, divide setup, one restoring quotient bit per stage,
// and the output register. One transaction enters per cycle unless rsp is stalled.
// Reset clears only the valid bits. A stall on rsp freezes the whole pipeline,
// and req_ready falls in the same cycle.
module complex_arith_unit_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cau_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cau_pkg::rsp_t rsp
);

    localparam int NS = cau_pkg::DIV_STEPS;
    localparam int FB = cau_pkg::FRAC_BITS;

    logic adv;

    // Stage 1: products and the results of the simple actions.
    logic               v1_reg;
    logic               is_mul1_reg, is_div1_reg, dz1_reg;
    cau_pkg::rsp_t      fast1_reg, fast1_next;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;

    // Stage 2: exact sums.
    logic               v2_reg;
    logic               is_mul2_reg, is_div2_reg, dz2_reg;
    cau_pkg::rsp_t      fast2_reg;
    logic signed [64:0] mre_reg, mim_reg, nre_reg, nim_reg;
    logic [63:0]        den2_reg;

    // Stage 3: multiply results and divide numerator magnitudes.
    logic               v3_reg;
    logic               is_div3_reg, dz3_reg;
    cau_pkg::rsp_t      fast3_reg, fast3_next;
    logic               neg_re3_reg, neg_im3_reg;
    logic [63:0]        mag_re_reg, mag_im_reg, den3_reg;

    // Divide pipeline: index 0 is the setup stage, then one stage per quotient bit.
    logic               vd_reg      [0:NS];
    logic               is_div_reg  [0:NS];
    logic               dz_reg      [0:NS];
    cau_pkg::rsp_t      fast_reg    [0:NS];
    logic               neg_re_reg  [0:NS];
    logic               neg_im_reg  [0:NS];
    logic               ovf_re_reg  [0:NS];
    logic               ovf_im_reg  [0:NS];
    logic [63:0]        den_reg     [0:NS];
    logic [63:0]        rem_re_reg  [0:NS];
    logic [63:0]        rem_im_reg  [0:NS];
    logic [31:0]        low_re_reg  [0:NS];
    logic [31:0]        low_im_reg  [0:NS];
    logic [31:0]        q_re_reg    [0:NS];
    logic [31:0]        q_im_reg    [0:NS];

    logic               out_v_reg;
    cau_pkg::rsp_t      out_reg, out_next;

    // The pipeline moves whenever the output register is free or being drained.
    assign adv       = !out_v_reg || rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = out_v_reg;
    assign rsp       = out_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            for (int i = 0; i <= NS; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= req_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int i = 1; i <= NS; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
            out_v_reg <= vd_reg[NS];
        end
    end

    // Add, subtract, compare and the zero-divisor case are settled in stage 1.
    always_comb
    begin
        cau_pkg::sat_t      a;
        cau_pkg::sat_t      b;
        logic signed [32:0] sr;
        logic signed [32:0] si;
        fast1_next = '0;
        sr = '0;
        si = '0;
        case (req.action)
            cau_pkg::ACT_ADD:
            begin
                sr = 33'(req.x_real) + 33'(req.y_real);
                si = 33'(req.x_imag) + 33'(req.y_imag);
            end
            cau_pkg::ACT_SUB:
            begin
                sr = 33'(req.x_real) - 33'(req.y_real);
                si = 33'(req.x_imag) - 33'(req.y_imag);
            end
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase
        a = cau_pkg::sat32(65'(sr));
        b = cau_pkg::sat32(65'(si));
        if (req.action == cau_pkg::ACT_ADD || req.action == cau_pkg::ACT_SUB)
        begin
            fast1_next.res_real  = a.val;
            fast1_next.res_imag  = b.val;
            fast1_next.saturated = a.clip | b.clip;
        end
        if (req.action == cau_pkg::ACT_CMP)
        begin
            fast1_next.is_equal = (req.x_real == req.y_real) && (req.x_imag == req.y_imag);
        end
        if (req.action == cau_pkg::ACT_DIV)
        begin
            fast1_next.div_zero = (req.y_real == 32'sd0) && (req.y_imag == 32'sd0);
        end
    end

    // Stage 3 combinational: floor-scaled multiply parts.
    always_comb
    begin
        cau_pkg::sat_t a;
        cau_pkg::sat_t b;
        a = cau_pkg::sat32(mre_reg >>> FB);
        b = cau_pkg::sat32(mim_reg >>> FB);
        fast3_next = fast2_reg;
        if (is_mul2_reg)
        begin
            fast3_next.res_real  = a.val;
            fast3_next.res_imag  = b.val;
            fast3_next.saturated = a.clip | b.clip;
        end
    end

    // Output selection: divide quotients are signed and clipped here.
    always_comb
    begin
        cau_pkg::sat_t a;
        cau_pkg::sat_t b;
        a = cau_pkg::quo_sat(neg_re_reg[NS], ovf_re_reg[NS], q_re_reg[NS]);
        b = cau_pkg::quo_sat(neg_im_reg[NS], ovf_im_reg[NS], q_im_reg[NS]);
        out_next = fast_reg[NS];
        if (is_div_reg[NS] && !dz_reg[NS])
        begin
            out_next.res_real  = a.val;
            out_next.res_imag  = b.val;
            out_next.saturated = a.clip | b.clip;
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: six 32x32 signed products.
            is_mul1_reg <= (req.action == cau_pkg::ACT_MUL);
            is_div1_reg <= (req.action == cau_pkg::ACT_DIV);
            dz1_reg     <= (req.y_real == 32'sd0) && (req.y_imag == 32'sd0);
            fast1_reg   <= fast1_next;
            p_rr_reg    <= 64'(req.x_real) * 64'(req.y_real);
            p_ii_reg    <= 64'(req.x_imag) * 64'(req.y_imag);
            p_ri_reg    <= 64'(req.x_real) * 64'(req.y_imag);
            p_ir_reg    <= 64'(req.x_imag) * 64'(req.y_real);
            sq_r_reg    <= 64'(req.y_real) * 64'(req.y_real);
            sq_i_reg    <= 64'(req.y_imag) * 64'(req.y_imag);

            // Stage 2: exact sums for both actions and the divisor.
            is_mul2_reg <= is_mul1_reg;
            is_div2_reg <= is_div1_reg;
            dz2_reg     <= dz1_reg;
            fast2_reg   <= fast1_reg;
            mre_reg     <= 65'(p_rr_reg) - 65'(p_ii_reg);
            mim_reg     <= 65'(p_ri_reg) + 65'(p_ir_reg);
            nre_reg     <= 65'(p_rr_reg) + 65'(p_ii_reg);
            nim_reg     <= 65'(p_ir_reg) - 65'(p_ri_reg);
            den2_reg    <= 64'(sq_r_reg) + 64'(sq_i_reg);

            // Stage 3: sign and magnitude of the divide numerators.
            is_div3_reg <= is_div2_reg;
            dz3_reg     <= dz2_reg;
            fast3_reg   <= fast3_next;
            neg_re3_reg <= nre_reg[64];
            neg_im3_reg <= nim_reg[64];
            mag_re_reg  <= nre_reg[64] ? 64'(-nre_reg) : nre_reg[63:0];
            mag_im_reg  <= nim_reg[64] ? 64'(-nim_reg) : nim_reg[63:0];
            den3_reg    <= den2_reg;

            // Divide setup: the high part of |num| * 2^FB seeds the remainder.
            // If it already reaches the divisor, the quotient is at least 2^32.
            is_div_reg[0] <= is_div3_reg;
            dz_reg[0]     <= dz3_reg;
            fast_reg[0]   <= fast3_reg;
            neg_re_reg[0] <= neg_re3_reg;
            neg_im_reg[0] <= neg_im3_reg;
            den_reg[0]    <= den3_reg;
            rem_re_reg[0] <= mag_re_reg >> (32 - FB);
            rem_im_reg[0] <= mag_im_reg >> (32 - FB);
            ovf_re_reg[0] <= (mag_re_reg >> (32 - FB)) >= den3_reg;
            ovf_im_reg[0] <= (mag_im_reg >> (32 - FB)) >= den3_reg;
            low_re_reg[0] <= {mag_re_reg[31-FB:0], {FB{1'b0}}};
            low_im_reg[0] <= {mag_im_reg[31-FB:0], {FB{1'b0}}};
            q_re_reg[0]   <= '0;
            q_im_reg[0]   <= '0;

            out_reg <= out_next;
        end
    end

    // Restoring division, one quotient bit per stage for both parts.
    for (genvar s = 1; s <= NS; s++)
    begin : g_div
        logic [63:0] t_re, t_im;
        logic        ge_re, ge_im;

        assign t_re  = {rem_re_reg[s-1][62:0], low_re_reg[s-1][31]};
        assign t_im  = {rem_im_reg[s-1][62:0], low_im_reg[s-1][31]};
        assign ge_re = t_re >= den_reg[s-1];
        assign ge_im = t_im >= den_reg[s-1];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                is_div_reg[s] <= is_div_reg[s-1];
                dz_reg[s]     <= dz_reg[s-1];
                fast_reg[s]   <= fast_reg[s-1];
                neg_re_reg[s] <= neg_re_reg[s-1];
                neg_im_reg[s] <= neg_im_reg[s-1];
                ovf_re_reg[s] <= ovf_re_reg[s-1];
                ovf_im_reg[s] <= ovf_im_reg[s-1];
                den_reg[s]    <= den_reg[s-1];
                rem_re_reg[s] <= ge_re ? t_re - den_reg[s-1] : t_re;
                rem_im_reg[s] <= ge_im ? t_im - den_reg[s-1] : t_im;
                low_re_reg[s] <= {low_re_reg[s-1][30:0], 1'b0};
                low_im_reg[s] <= {low_im_reg[s-1][30:0], 1'b0};
                q_re_reg[s]   <= {q_re_reg[s-1][30:0], ge_re};
                q_im_reg[s]   <= {q_im_reg[s-1][30:0], ge_im};
            end
        end
    end

endmodule

/* design/cau_checker.sv */
module cau_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input cau_pkg::rsp_t rsp
);

    // A result waiting on the output holds until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // Input is refused only while a result is stuck on the output.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("req_ready low without output stall");

    // A zero divisor gives zero parts and no clipping.
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.div_zero |-> rsp.res_real == 32'sd0 && rsp.res_imag == 32'sd0
            && !rsp.saturated && !rsp.is_equal)
        else $error("div_zero result not clean");

    // A compare result carries no arithmetic parts.
    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_equal |-> rsp.res_real == 32'sd0 && rsp.res_imag == 32'sd0
            && !rsp.saturated)
        else $error("compare result carries data");

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (.*);

/* test/complex_arith_unit_top_test.sv */
`timescale 1ns / 100ps

module complex_arith_unit_top_test;

    localparam int LATENCY = cau_pkg::DIV_STEPS + 5;
    localparam int STALL_LIMIT = 4000;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    cau_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_ready;
    cau_pkg::rsp_t  rsp;

    cau_pkg::rsp_t  expected_results[$];
    int    error_count;
    int    results_seen;
    int    items_sent;
    int    idle_cycles;
    bit    quiet_mode;
    bit    hold_results;
    int    hold_length;
    int    op_counts[8];

    complex_arith_unit_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Clip an exact signed value to 32 bits, noting whether it was clipped.
    function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Quotient truncated toward zero.
    function automatic logic signed [127:0] trunc_div(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q = mag / den;
        return (num < 0) ? -q : q;
    endfunction

    // Compute the complex ALU result for one operand pair.
    function automatic cau_pkg::rsp_t complex_result(input cau_pkg::req_t r);
        cau_pkg::rsp_t       o;
        logic signed [127:0] xr;
        logic signed [127:0] xi;
        logic signed [127:0] yr;
        logic signed [127:0] yi;
        logic signed [127:0] re;
        logic signed [127:0] im;
        logic signed [127:0] den;
        logic                sat;
        xr = r.x_real;
        xi = r.x_imag;
        yr = r.y_real;
        yi = r.y_imag;
        o = '0;
        sat = 1'b0;
        case (r.action)
            cau_pkg::ACT_ADD:
            begin
                o.res_real = clip32(xr + yr, sat);
                o.res_imag = clip32(xi + yi, sat);
            end
            cau_pkg::ACT_SUB:
            begin
                o.res_real = clip32(xr - yr, sat);
                o.res_imag = clip32(xi - yi, sat);
            end
            cau_pkg::ACT_MUL:
            begin
                // Arithmetic shift gives rounding toward minus infinity.
                re = (xr * yr - xi * yi) >>> cau_pkg::FRAC_BITS;
                im = (xr * yi + xi * yr) >>> cau_pkg::FRAC_BITS;
                o.res_real = clip32(re, sat);
                o.res_imag = clip32(im, sat);
            end
            cau_pkg::ACT_DIV:
            begin
                if (r.y_real == 0 && r.y_imag == 0)
                    o.div_zero = 1'b1;
                else
                begin
                    den = yr * yr + yi * yi;
                    re = trunc_div((xr * yr + xi * yi) <<< cau_pkg::FRAC_BITS, den);
                    im = trunc_div((xi * yr - xr * yi) <<< cau_pkg::FRAC_BITS, den);
                    o.res_real = clip32(re, sat);
                    o.res_imag = clip32(im, sat);
                end
            end
            cau_pkg::ACT_CMP:
                o.is_equal = (r.x_real == r.y_real) && (r.x_imag == r.y_imag);
            default:
                o = '0;
        endcase
        o.saturated = (r.action == cau_pkg::ACT_DIV && o.div_zero) ? 1'b0 : sat;
        return o;
    endfunction

    // Offer one transaction and hold it until it is accepted.
    task automatic send_item(input cau_pkg::req_t item);
        while (!quiet_mode && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_results.push_back(complex_result(item));
        op_counts[item.action]++;
        items_sent++;
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(255) << cau_pkg::FRAC_BITS;
            2: return -($urandom_range(255) << cau_pkg::FRAC_BITS);
            3: return {{16{1'b0}}, 16'($urandom)};
            4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(4000)) - 2000) <<< 10;
        endcase
    endfunction

    function automatic cau_pkg::req_t random_item();
        cau_pkg::req_t r;
        r.action = ($urandom_range(49) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        r.x_real = rand_part();
        r.x_imag = rand_part();
        r.y_real = rand_part();
        r.y_imag = rand_part();
        // Equal operands and a zero divisor need to be forced now and then.
        if ($urandom_range(9) == 0)
        begin
            r.y_real = r.x_real;
            r.y_imag = r.x_imag;
        end
        if (r.action == cau_pkg::ACT_DIV && $urandom_range(9) == 0)
        begin
            r.y_real = 0;
            r.y_imag = 0;
        end
        return r;
    endfunction

    function automatic cau_pkg::req_t make_item(input logic [2:0] act, input logic [31:0] a,
                                                input logic [31:0] b, input logic [31:0] c,
                                                input logic [31:0] d);
        cau_pkg::req_t r;
        r.action = act;
        r.x_real = a;
        r.x_imag = b;
        r.y_real = c;
        r.y_imag = d;
        return r;
    endfunction

    // The input goes idle and waits for every outstanding result.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, every action, zero divisor, equality and unused action codes.
    task automatic test_directed();
        send_item(make_item(cau_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_item(cau_pkg::ACT_ADD, 32'h0001_0000, 32'hFFFF_0000,
                            32'h0002_8000, 32'h0));
        send_item(make_item(cau_pkg::ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h0000_0001, 32'hFFFF_FFFF));
        send_item(make_item(cau_pkg::ACT_SUB, 32'h0003_0000, 32'h0001_0000,
                            32'h0001_0000, 32'h0003_0000));
        send_item(make_item(cau_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000));
        send_item(make_item(cau_pkg::ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_item(cau_pkg::ACT_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0));
        send_item(make_item(cau_pkg::ACT_MUL, 32'h0002_0000, 32'h0003_0000,
                            32'h0004_0000, 32'hFFFB_0000));
        send_item(make_item(cau_pkg::ACT_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0));
        send_item(make_item(cau_pkg::ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0000_0001, 32'h0));
        send_item(make_item(cau_pkg::ACT_DIV, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000));
        send_item(make_item(cau_pkg::ACT_DIV, 32'hFFFF_0000, 32'h0, 32'h0003_0000, 32'h0));
        send_item(make_item(cau_pkg::ACT_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0000_0001));
        send_item(make_item(cau_pkg::ACT_CMP, 32'h1234_5678, 32'h8000_0000,
                            32'h1234_5678, 32'h8000_0000));
        send_item(make_item(cau_pkg::ACT_CMP, 32'h1234_5678, 32'h0, 32'h1234_5678, 32'h1));
        send_item(make_item(cau_pkg::ACT_CMP, 32'h0, 32'h0, 32'h0, 32'h0));
        send_item(make_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(3'd6, 32'h1, 32'h2, 32'h3, 32'h4));
        send_item(make_item(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        wait_drained();
    endtask

    // Random traffic with random idling on both sides.
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_item(random_item());
    endtask

    // Back-to-back traffic with no idling at all.
    task automatic test_streaming(input int count);
        quiet_mode = 1'b1;
        for (int i = 0; i < count; i++)
            send_item(random_item());
        quiet_mode = 1'b0;
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_backpressure();
        hold_length  = 3 * LATENCY;
        hold_results = 1'b1;
        for (int i = 0; i < LATENCY + 20; i++)
            send_item(random_item());
        wait_drained();
    endtask

    // Result acceptance with random stalls and the long hold-off.
    always @(posedge clk)
    begin
        if (hold_results)
        begin
            rsp_ready <= 1'b0;
            if (hold_length == 0)
                hold_results <= 1'b0;
            else
                hold_length <= hold_length - 1;
        end
        else
            rsp_ready <= quiet_mode || ($urandom_range(99) >= 6);
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        cau_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result with no transaction outstanding");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.res_real !== want.res_real)
                begin
                    $error("res_real: expected %h, got %h", want.res_real, rsp.res_real);
                    error_count++;
                end
                if (rsp.res_imag !== want.res_imag)
                begin
                    $error("res_imag: expected %h, got %h", want.res_imag, rsp.res_imag);
                    error_count++;
                end
                if (rsp.is_equal !== want.is_equal)
                begin
                    $error("is_equal: expected %b, got %b", want.is_equal, rsp.is_equal);
                    error_count++;
                end
                if (rsp.div_zero !== want.div_zero)
                begin
                    $error("div_zero: expected %b, got %b", want.div_zero, rsp.div_zero);
                    error_count++;
                end
                if (rsp.saturated !== want.saturated)
                begin
                    $error("saturated: expected %b, got %b", want.saturated, rsp.saturated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_ready    = 1'b0;
        error_count  = 0;
        results_seen = 0;
        items_sent   = 0;
        idle_cycles  = 0;
        quiet_mode   = 1'b0;
        hold_results = 1'b0;
        hold_length  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250);
        test_backpressure();
        test_streaming(150);
        // The sender pauses until every result is back.
        wait_drained();
        test_random(190);

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d transactions, checked %0d results.", items_sent, results_seen);
        $display("Actions add/sub/mul/div/cmp/other: %0d/%0d/%0d/%0d/%0d/%0d", op_counts[0],
                 op_counts[1], op_counts[2], op_counts[3], op_counts[4],
                 op_counts[5] + op_counts[6] + op_counts[7]);
        if (error_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
